// ===== rtl/core/wsst_pkg.sv =====
`default_nettype none

package wsst_pkg;

	localparam int IDX_W  = 10;
	localparam int WGT_W  = 32;
	localparam int FRAC_W = 32;
	localparam int TOT_W  = 42;

	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_DRAW = 2'd1,
		OP_READ = 2'd2
	} op_t;

endpackage

`default_nettype wire

// ===== rtl/core/wsst_node_ram.sv =====
`default_nettype none

module wsst_node_ram #(
	parameter int DEPTH  = 2046,
	parameter int AW     = 11,
	parameter int DATA_W = 42
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/wsst_scale.sv =====
`default_nettype none

module wsst_scale
	import wsst_pkg::*;
#(
	parameter int NODE_W = 42
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [FRAC_W-1:0] fraction,
	input  wire logic [NODE_W-1:0] total,
	output logic                   valid,
	output logic      [NODE_W-1:0] target,
	output logic                   rem
);

	localparam int HI_W = NODE_W - WGT_W;

	logic                  v_s1;
	logic [63:0]           plo_s1;
	logic [HI_W-1:0]       hi_s1;
	logic [FRAC_W-1:0]     frac_s1;
	logic [NODE_W-1:0]     prod_hi;

	assign prod_hi = NODE_W'(frac_s1) * NODE_W'(hi_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			valid <= 1'b0;
		end else begin
			v_s1  <= go;
			valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		plo_s1  <= 64'(fraction) * 64'(total[WGT_W-1:0]);
		hi_s1   <= total[NODE_W-1:WGT_W];
		frac_s1 <= fraction;
		target  <= prod_hi + NODE_W'(plo_s1[63:32]);
		rem     <= (plo_s1[31:0] != 32'd0);
	end

endmodule

`default_nettype wire

// ===== rtl/core/weighted_sampling_sum_tree_top.sv =====
// Channel   Handshake      Payload
// command   start, busy    op, item_index, new_weight, fraction
// result    done           chosen_index, item_weight, total_weight, empty_res
//
// A word is taken when start is high and busy is low; one command is in flight at a time.
// Each tree level of a set or a draw costs one read-modify-write or one read of the node memory.
// After reset a clearing pass zeroes all 2*TOP-2 entries of the node memory while busy is high.
// The result stands for one cycle with done high; it cannot be stalled.
`default_nettype none

module weighted_sampling_sum_tree_top
	import wsst_pkg::*;
#(
	parameter int LEAVES = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [IDX_W-1:0]  item_index,
	input  wire logic [WGT_W-1:0]  new_weight,
	input  wire logic [FRAC_W-1:0] fraction,
	output logic                   done,
	output logic      [IDX_W-1:0]  chosen_index,
	output logic      [WGT_W-1:0]  item_weight,
	output logic      [TOT_W-1:0]  total_weight,
	output logic                   empty_res
);

	localparam int LVL    = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
	localparam int TOP    = 1 << LVL;
	localparam int NODES  = 2 * TOP - 2;
	localparam int AW     = (NODES <= 2) ? 1 : $clog2(NODES);
	localparam int NODE_W = WGT_W + LVL;
	localparam int BASE   = TOP - 2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_WAIT,
		ST_SET_LEAF,
		ST_SET_UP,
		ST_DRAW_MUL,
		ST_DRAW_WALK
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      k_q;
	logic [WGT_W-1:0]   w_q;
	logic [NODE_W-1:0]  delta_q;
	logic [NODE_W-1:0]  total_q;
	logic [NODE_W-1:0]  t_q;
	logic [NODE_W-1:0]  pair_q;
	logic               rem_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [NODE_W-1:0]  wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [NODE_W-1:0]  rd_data;

	logic               sc_valid;
	logic [NODE_W-1:0]  sc_target;
	logic               sc_rem;

	logic               accept;
	logic               in_range;
	logic [AW-1:0]      leaf_addr;
	logic [AW-1:0]      parent;
	logic               at_leaf;
	logic               go_right;
	logic [AW-1:0]      next_k;
	logic [NODE_W-1:0]  delta;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign in_range  = (32'(item_index) < 32'(LEAVES));
	assign leaf_addr = AW'(32'(BASE) + 32'(item_index));
	assign parent    = (k_q >> 1) - AW'(1);
	assign at_leaf   = (32'(k_q) >= 32'(BASE));
	assign go_right  = (t_q > rd_data) || ((t_q == rd_data) && rem_q);
	assign next_k    = go_right ? AW'((32'(k_q) + 32'd2) * 32'd2)
	                            : AW'((32'(k_q) + 32'd1) * 32'd2);
	assign delta     = NODE_W'(w_q) - rd_data;

	wsst_node_ram #(
		.DEPTH  (NODES),
		.AW     (AW),
		.DATA_W (NODE_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wsst_scale #(
		.NODE_W (NODE_W)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (accept && (op_t'(op) == OP_DRAW)),
		.fraction (fraction),
		.total    (total_q),
		.valid    (sc_valid),
		.target   (sc_target),
		.rem      (sc_rem)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = k_q;
		wr_en   = 1'b0;
		wr_addr = k_q;
		wr_data = rd_data + delta_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				if (accept && (op_t'(op) != OP_DRAW) && in_range) begin
					rd_en   = 1'b1;
					rd_addr = leaf_addr;
				end
			end
			ST_SET_LEAF: begin
				wr_en   = 1'b1;
				wr_data = NODE_W'(w_q);
				if (k_q > AW'(1)) begin
					rd_en   = 1'b1;
					rd_addr = parent;
				end
			end
			ST_SET_UP: begin
				wr_en = 1'b1;
				if (k_q > AW'(1)) begin
					rd_en   = 1'b1;
					rd_addr = parent;
				end
			end
			ST_DRAW_MUL: begin
				if (sc_valid) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			ST_DRAW_WALK: begin
				if (!at_leaf) begin
					rd_en   = 1'b1;
					rd_addr = next_k;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			total_q      <= '0;
			done         <= 1'b0;
			k_q          <= '0;
			w_q          <= '0;
			delta_q      <= '0;
			t_q          <= '0;
			pair_q       <= '0;
			rem_q        <= 1'b0;
			chosen_index <= '0;
			item_weight  <= '0;
			total_weight <= '0;
			empty_res    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						chosen_index <= item_index;
						empty_res    <= 1'b0;
						k_q          <= leaf_addr;
						w_q          <= new_weight;
						case (op_t'(op))
							OP_SET: begin
								if (in_range) begin
									state_q <= ST_SET_LEAF;
								end else begin
									done         <= 1'b1;
									item_weight  <= '0;
									total_weight <= TOT_W'(total_q);
								end
							end
							OP_DRAW: begin
								state_q <= ST_DRAW_MUL;
							end
							default: begin
								if (in_range) begin
									state_q <= ST_READ_WAIT;
								end else begin
									done         <= 1'b1;
									item_weight  <= '0;
									total_weight <= TOT_W'(total_q);
								end
							end
						endcase
					end
				end
				ST_READ_WAIT: begin
					done         <= 1'b1;
					item_weight  <= WGT_W'(rd_data);
					total_weight <= TOT_W'(total_q);
					state_q      <= ST_IDLE;
				end
				ST_SET_LEAF: begin
					delta_q <= delta;
					total_q <= total_q + delta;
					if (k_q > AW'(1)) begin
						k_q     <= parent;
						state_q <= ST_SET_UP;
					end else begin
						done         <= 1'b1;
						item_weight  <= w_q;
						total_weight <= TOT_W'(total_q + delta);
						state_q      <= ST_IDLE;
					end
				end
				ST_SET_UP: begin
					if (k_q > AW'(1)) begin
						k_q <= parent;
					end else begin
						done         <= 1'b1;
						item_weight  <= w_q;
						total_weight <= TOT_W'(total_q);
						state_q      <= ST_IDLE;
					end
				end
				ST_DRAW_MUL: begin
					if (sc_valid) begin
						t_q       <= sc_target;
						rem_q     <= sc_rem;
						pair_q    <= total_q;
						k_q       <= '0;
						empty_res <= (total_q == '0);
						state_q   <= ST_DRAW_WALK;
					end
				end
				ST_DRAW_WALK: begin
					if (go_right) begin
						t_q    <= t_q - rd_data;
						pair_q <= pair_q - rd_data;
					end else begin
						pair_q <= rd_data;
					end
					if (at_leaf) begin
						done         <= 1'b1;
						chosen_index <= IDX_W'(32'(k_q) - 32'(BASE) + (go_right ? 32'd1 : 32'd0));
						item_weight  <= go_right ? WGT_W'(pair_q - rd_data) : WGT_W'(rd_data);
						total_weight <= TOT_W'(total_q);
						state_q      <= ST_IDLE;
					end else begin
						k_q <= next_k;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a command is still in flight");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && empty_res) |-> (total_weight == '0))
		else $error("empty flag with nonzero total");

	a_scale_state: assert property (@(posedge clk) disable iff (!arst_n)
		sc_valid |-> (state_q == ST_DRAW_MUL))
		else $error("scaled target arrived outside a draw");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("node read and write hit the same entry");
`endif

endmodule

`default_nettype wire
